### hdl/sams_pkg.sv
// ----------------------------------------------------------------------------
// sams_pkg: shared types, constants and control program
// Payload structs, register codes, microcode ops and the control store of the
// signed acceleration magnitude smoother.
// ----------------------------------------------------------------------------
package sams_pkg;

  // History depth and derived widths
  localparam int WINDOW     = 5;
  localparam int MAG_W      = 15;
  localparam int FILL_W     = $clog2(WINDOW + 1);
  localparam int IDX_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W      = $clog2(WINDOW * (1 << MAG_W));
  localparam int SQRT_ITERS = 16;
  localparam int CNT_MAX    = (SUM_W > SQRT_ITERS) ? SUM_W : SQRT_ITERS;
  localparam int CNT_W      = $clog2(CNT_MAX);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT = 1'd1;
  localparam logic [MAG_W-1:0] RAW_LIMIT_RST = 15'd1536;
  localparam logic [MAG_W-1:0] OUT_LIMIT_RST = 15'd2048;

  // Control store addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] S_WAIT = 4'd0;
  localparam logic [PC_W-1:0] S_MSX  = 4'd1;
  localparam logic [PC_W-1:0] S_MSY  = 4'd2;
  localparam logic [PC_W-1:0] S_MDX  = 4'd3;
  localparam logic [PC_W-1:0] S_MDY  = 4'd4;
  localparam logic [PC_W-1:0] S_MDZ  = 4'd5;
  localparam logic [PC_W-1:0] S_SQI  = 4'd6;
  localparam logic [PC_W-1:0] S_SQS  = 4'd7;
  localparam logic [PC_W-1:0] S_STO  = 4'd8;
  localparam logic [PC_W-1:0] S_SUM  = 4'd9;
  localparam logic [PC_W-1:0] S_DVI  = 4'd10;
  localparam logic [PC_W-1:0] S_DVS  = 4'd11;
  localparam logic [PC_W-1:0] S_FIN  = 4'd12;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic               first_call;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] accel_out;
  } out_item_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_WAIT, // take a transaction
    OP_MSX,  // ax*ax
    OP_MSY,  // ay*ay, load square sum
    OP_MDX,  // vx*ax, add square
    OP_MDY,  // vy*ay, load dot
    OP_MDZ,  // vz*az, add dot
    OP_SQI,  // add dot, start root
    OP_SQS,  // one root iteration
    OP_STO,  // clamp and store magnitude
    OP_SUM,  // add one history entry
    OP_DVI,  // start divide
    OP_DVS,  // one quotient bit
    OP_FIN   // sign, clamp, load output
  } op_e;

  // Sequencing: hold on the step while the condition is true, else go to target
  typedef enum logic [2:0] {
    JK_GO,
    JK_HOLD_NO_IN,
    JK_HOLD_CNT,
    JK_HOLD_SUM,
    JK_HOLD_OUT
  } jmp_e;

  typedef struct packed {
    op_e             op;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    op_e op;
  } dp_ctrl_t;

  typedef struct packed {
    logic in_acc;
    logic cnt_nz;
    logic sum_more;
    logic out_busy;
  } dp_stat_t;

  // Control store
  function automatic ctrl_word_t rom_word(input logic [PC_W-1:0] step);
    ctrl_word_t w;
    case (step)
      S_WAIT:  w = '{op: OP_WAIT, jmp: JK_HOLD_NO_IN, target: S_MSX};
      S_MSX:   w = '{op: OP_MSX,  jmp: JK_GO,         target: S_MSY};
      S_MSY:   w = '{op: OP_MSY,  jmp: JK_GO,         target: S_MDX};
      S_MDX:   w = '{op: OP_MDX,  jmp: JK_GO,         target: S_MDY};
      S_MDY:   w = '{op: OP_MDY,  jmp: JK_GO,         target: S_MDZ};
      S_MDZ:   w = '{op: OP_MDZ,  jmp: JK_GO,         target: S_SQI};
      S_SQI:   w = '{op: OP_SQI,  jmp: JK_GO,         target: S_SQS};
      S_SQS:   w = '{op: OP_SQS,  jmp: JK_HOLD_CNT,   target: S_STO};
      S_STO:   w = '{op: OP_STO,  jmp: JK_GO,         target: S_SUM};
      S_SUM:   w = '{op: OP_SUM,  jmp: JK_HOLD_SUM,   target: S_DVI};
      S_DVI:   w = '{op: OP_DVI,  jmp: JK_GO,         target: S_DVS};
      S_DVS:   w = '{op: OP_DVS,  jmp: JK_HOLD_CNT,   target: S_FIN};
      S_FIN:   w = '{op: OP_FIN,  jmp: JK_HOLD_OUT,   target: S_WAIT};
      default: w = '{op: OP_WAIT, jmp: JK_GO,         target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

### hdl/sams_if.sv
// ----------------------------------------------------------------------------
// sams_if: valid/ready channels
// Input sample channel and result channel of the smoother.
// ----------------------------------------------------------------------------
interface sams_in_if;
  logic               valid;
  logic               ready;
  sams_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sams_out_if;
  logic                valid;
  logic                ready;
  sams_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/sams_seq.sv
// ----------------------------------------------------------------------------
// sams_seq: microcode sequencer
// Step counter over the control store, with hold-while-condition jumps.
// ----------------------------------------------------------------------------
module sams_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sams_pkg::dp_stat_t  stat_i,
  output sams_pkg::dp_ctrl_t  ctrl_o
);

  logic [sams_pkg::PC_W-1:0] pc_q, pc_d;
  sams_pkg::ctrl_word_t      word;
  logic                      hold;

  // Fetch the control word of the current step
  always_comb begin
    word = sams_pkg::rom_word(pc_q);
    ctrl_o.op = word.op;
  end

  // Evaluate the hold condition
  always_comb begin
    case (word.jmp)
      sams_pkg::JK_GO:         hold = 1'b0;
      sams_pkg::JK_HOLD_NO_IN: hold = !stat_i.in_acc;
      sams_pkg::JK_HOLD_CNT:   hold = stat_i.cnt_nz;
      sams_pkg::JK_HOLD_SUM:   hold = stat_i.sum_more;
      sams_pkg::JK_HOLD_OUT:   hold = stat_i.out_busy;
      default:                 hold = 1'b0;
    endcase
    pc_d = hold ? pc_q : word.target;
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= sams_pkg::S_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

### hdl/sams_dp.sv
// ----------------------------------------------------------------------------
// sams_dp: smoother datapath
// Shared multiplier, root and divide registers, history, limits and the
// output register, each driven by the op of the current control word.
// ----------------------------------------------------------------------------
module sams_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sams_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sams_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  sams_pkg::dp_ctrl_t                  ctrl_i,
  output sams_pkg::dp_stat_t                  stat_o,
  sams_in_if.sink                             in_i,
  sams_out_if.source                          out_o
);

  localparam int MW = sams_pkg::MAG_W;
  localparam int SW = sams_pkg::SUM_W;
  localparam int FW = sams_pkg::FILL_W;
  localparam int IW = sams_pkg::IDX_W;
  localparam int CW = sams_pkg::CNT_W;
  localparam int WIN = sams_pkg::WINDOW;

  logic [MW-1:0] raw_limit_q, out_limit_q;

  sams_pkg::in_item_t item_q;
  logic               in_acc;

  logic signed [15:0] mul_a, mul_b;
  logic signed [31:0] prod_q;
  logic [31:0]        sq_q;
  logic signed [33:0] dot_q;

  logic [31:0]   rem_q, root_q, bit_q;
  logic [CW-1:0] cnt_q;
  logic [SW-1:0] sum_q;

  logic [MW-1:0] hist_q [WIN];
  logic [FW-1:0] fill_q;
  logic [IW-1:0] wslot_q, idx_q;

  logic signed [15:0] out_q;
  logic               out_valid_q;

  logic [31:0]   sq_t;
  logic [31:0]   dv_r;
  logic [MW-1:0] mag;
  logic [MW-1:0] avg_c;
  logic signed [15:0] res;

  // Handshake and status
  assign in_acc       = in_i.valid && (ctrl_i.op == sams_pkg::OP_WAIT);
  assign in_i.ready   = (ctrl_i.op == sams_pkg::OP_WAIT);
  assign out_o.valid  = out_valid_q;
  assign out_o.data.accel_out = out_q;

  assign stat_o.in_acc   = in_acc;
  assign stat_o.cnt_nz   = (cnt_q != '0);
  assign stat_o.sum_more = ((FW'(idx_q) + FW'(1)) != fill_q);
  assign stat_o.out_busy = out_valid_q && !out_o.ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_limit_q <= sams_pkg::RAW_LIMIT_RST;
      out_limit_q <= sams_pkg::OUT_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sams_pkg::CFG_RAW_LIMIT: raw_limit_q <= cfg_data_i;
        sams_pkg::CFG_OUT_LIMIT: out_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Select multiplier operands
  always_comb begin
    case (ctrl_i.op)
      sams_pkg::OP_MSX: begin mul_a = item_q.accel_x; mul_b = item_q.accel_x; end
      sams_pkg::OP_MSY: begin mul_a = item_q.accel_y; mul_b = item_q.accel_y; end
      sams_pkg::OP_MDX: begin mul_a = item_q.vel_x;   mul_b = item_q.accel_x; end
      sams_pkg::OP_MDY: begin mul_a = item_q.vel_y;   mul_b = item_q.accel_y; end
      sams_pkg::OP_MDZ: begin mul_a = item_q.vel_z;   mul_b = item_q.accel_z; end
      default:          begin mul_a = item_q.accel_x; mul_b = item_q.accel_x; end
    endcase
  end

  // Root trial, divide trial, magnitude clamp and output shaping
  always_comb begin
    sq_t  = root_q + bit_q;
    dv_r  = {rem_q[30:0], sum_q[SW-1]};
    mag   = (root_q[15:0] > {1'b0, raw_limit_q}) ? raw_limit_q : root_q[MW-1:0];
    avg_c = (sum_q[MW-1:0] > out_limit_q) ? out_limit_q : sum_q[MW-1:0];
    if (item_q.first_call) begin
      res = '0;
    end else if (dot_q[33]) begin
      res = -$signed({1'b0, avg_c});
    end else begin
      res = $signed({1'b0, avg_c});
    end
  end

  // Payload registers of the datapath
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      sams_pkg::OP_WAIT: begin
        if (in_acc) item_q <= in_i.data;
      end
      sams_pkg::OP_MSX: prod_q <= mul_a * mul_b;
      sams_pkg::OP_MSY: begin
        prod_q <= mul_a * mul_b;
        sq_q   <= prod_q;
      end
      sams_pkg::OP_MDX: begin
        prod_q <= mul_a * mul_b;
        sq_q   <= sq_q + 32'(prod_q);
      end
      sams_pkg::OP_MDY: begin
        prod_q <= mul_a * mul_b;
        dot_q  <= 34'(prod_q);
      end
      sams_pkg::OP_MDZ: begin
        prod_q <= mul_a * mul_b;
        dot_q  <= dot_q + 34'(prod_q);
      end
      sams_pkg::OP_SQI: begin
        dot_q  <= dot_q + 34'(prod_q);
        rem_q  <= sq_q;
        root_q <= '0;
        bit_q  <= 32'h4000_0000;
      end
      sams_pkg::OP_SQS: begin
        if (rem_q >= sq_t) begin
          rem_q  <= rem_q - sq_t;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      sams_pkg::OP_STO: begin
        hist_q[wslot_q] <= mag;
        sum_q           <= '0;
      end
      sams_pkg::OP_SUM: sum_q <= sum_q + SW'(hist_q[idx_q]);
      sams_pkg::OP_DVI: rem_q <= '0;
      sams_pkg::OP_DVS: begin
        if (dv_r >= 32'(fill_q)) begin
          rem_q <= dv_r - 32'(fill_q);
          sum_q <= {sum_q[SW-2:0], 1'b1};
        end else begin
          rem_q <= dv_r;
          sum_q <= {sum_q[SW-2:0], 1'b0};
        end
      end
      sams_pkg::OP_FIN: begin
        if (!stat_o.out_busy) out_q <= res;
      end
      default: ;
    endcase
  end

  // Control registers: counters, history pointers and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      fill_q      <= '0;
      wslot_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      case (ctrl_i.op)
        sams_pkg::OP_SQI: cnt_q <= CW'(sams_pkg::SQRT_ITERS - 1);
        sams_pkg::OP_SQS: begin
          if (cnt_q != '0) cnt_q <= cnt_q - CW'(1);
        end
        sams_pkg::OP_STO: begin
          idx_q   <= '0;
          wslot_q <= (wslot_q == IW'(WIN - 1)) ? '0 : wslot_q + IW'(1);
          if (fill_q < FW'(WIN)) fill_q <= fill_q + FW'(1);
        end
        sams_pkg::OP_SUM: begin
          if (stat_o.sum_more) idx_q <= idx_q + IW'(1);
        end
        sams_pkg::OP_DVI: cnt_q <= CW'(SW - 1);
        sams_pkg::OP_DVS: begin
          if (cnt_q != '0) cnt_q <= cnt_q - CW'(1);
        end
        sams_pkg::OP_FIN: begin
          if (!stat_o.out_busy) out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

### hdl/signed_accel_magnitude_smoother_unit.sv
// ----------------------------------------------------------------------------
// signed_accel_magnitude_smoother_unit: signed acceleration smoother
// Planar magnitude by square root, upper clamp, 5-entry moving average,
// sign from velocity dot acceleration and a symmetric output clamp.
// ----------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  in_i      sink       valid/ready    accel_x/y/z, vel_x/y/z, first_call
//  out_o     source     valid/ready    accel_out
//  cfg       input      cfg_we_i       cfg_idx_i, cfg_data_i (15 bit)
//
//  One sample runs from its accept to its result being loaded through
//  five multiplies on the shared multiplier, 16 root iterations, n adds over
//  the history, n being the filled history entries (1..5), and 18 divide steps.
//  A new sample is taken the cycle after the result is loaded into the output
//  register, even while that result still waits for out_o.ready.
//  Reset clears the sequencer, history counters and output valid at once.
//  A stalled result holds the sequencer on its final step until the output
//  register frees.
// ----------------------------------------------------------------------------
module signed_accel_magnitude_smoother_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sams_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sams_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  sams_in_if.sink                          in_i,
  sams_out_if.source                       out_o
);

  sams_pkg::dp_ctrl_t ctrl;
  sams_pkg::dp_stat_t stat;

  // Sequencer
  sams_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // Datapath
  sams_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .in_i       (in_i),
    .out_o      (out_o)
  );

endmodule

### hdl/sams_checker.sv
// ----------------------------------------------------------------------------
// sams_checker: port-level checks of the smoother
// Output handshake rules and one-sample-at-a-time behavior.
// ----------------------------------------------------------------------------
module sams_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_data_i
);

  // Hold a pending result until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Keep a stalled result stable
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  // Drop ready once a sample transaction is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second sample taken while busy");

  // No result appears right after a sample transaction
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result raised too early");

  // Clamp never yields the most negative code
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i != 16'h8000)
    else $error("result outside clamp range");

endmodule

bind signed_accel_magnitude_smoother_unit sams_checker u_sams_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data.accel_out)
);
